/* rtl/core/gbr_pkg.sv */
// Shared types and constants for the 3x3 RGB Gaussian blur.
`timescale 1ns / 1ps
`default_nettype none

package gbr_pkg;

   localparam int CHAN_W      = 8;
   localparam int FRAME_W_W   = 11;
   localparam int FRAME_H_W   = 16;
   localparam int ROW_W       = 17;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int SUM_W       = 12;

   localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 4'd0,
      CSR_FRAME_HEIGHT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic              is_flush;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              end_of_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // One line-memory word: the pixel two rows up and the one a row up.
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_word_type;

   // [row top..bottom][column left..right], column 2 is the newest.
   typedef pixel_type [2:0][2:0] window_type;

   typedef struct packed {
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
   } tap_mask_type;

endpackage

`default_nettype wire

/* rtl/core/gbr_line_mem.sv */
// Line memory holding the two previous rows, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none

module gbr_line_mem #(
   parameter int DEPTH = 1024
) (
   input  wire                           clock,
   input  wire                           rd_en,
   input  wire  [$clog2(DEPTH)-1:0]      rd_addr,
   output gbr_pkg::line_word_type        rd_data,
   input  wire                           wr_en,
   input  wire  [$clog2(DEPTH)-1:0]      wr_addr,
   input  gbr_pkg::line_word_type        wr_data
);
   import gbr_pkg::*;

   line_word_type mem_ff [DEPTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read returns the old word on a same-address write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/gbr_kernel.sv */
// 1-2-1 / 2-4-2 / 1-2-1 kernel over a 3x3 window with border masking.
`timescale 1ns / 1ps
`default_nettype none

module gbr_kernel (
   input  gbr_pkg::window_type    window,
   input  gbr_pkg::tap_mask_type  mask,
   output gbr_pkg::pixel_type     blurred
);
   import gbr_pkg::*;

   logic [2:0]       row_ok;
   logic [2:0]       col_ok;
   logic [SUM_W-1:0] sum_r;
   logic [SUM_W-1:0] sum_g;
   logic [SUM_W-1:0] sum_b;
   logic [SUM_W-1:0] rnd_r;
   logic [SUM_W-1:0] rnd_g;
   logic [SUM_W-1:0] rnd_b;

   assign row_ok = {mask.bot_ok, 1'b1, mask.top_ok};
   assign col_ok = {mask.right_ok, 1'b1, mask.left_ok};

   // Weights are powers of two: shift by one per center row or column.
   always_comb begin
      int sh;
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sh = ((i == 1) ? 1 : 0) + ((j == 1) ? 1 : 0);
            if (row_ok[i] && col_ok[j]) begin
               sum_r = sum_r + (SUM_W'(window[i][j].red) << sh);
               sum_g = sum_g + (SUM_W'(window[i][j].green) << sh);
               sum_b = sum_b + (SUM_W'(window[i][j].blue) << sh);
            end
         end
      end
   end

   // Round half up, divide by 16; the sum stays below 4088.
   assign rnd_r = sum_r + SUM_W'(8);
   assign rnd_g = sum_g + SUM_W'(8);
   assign rnd_b = sum_b + SUM_W'(8);

   assign blurred.red   = rnd_r[SUM_W-1:4];
   assign blurred.green = rnd_g[SUM_W-1:4];
   assign blurred.blue  = rnd_b[SUM_W-1:4];

endmodule

`default_nettype wire

/* rtl/core/gaussian_blur_3x3_rgb.sv */
// Top level of the streaming 3x3 Gaussian blur of an RGB frame.
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one pixel per clock unless the output stalls; a single line memory with one read
//   and one write port per cycle carries both stored rows, so each unstalled cycle takes one item.
// Pipeline: the item that completes a neighborhood passes memory read, then window shift,
//   then kernel into the output register, before rsp_valid rises; a stall can hold it.
// Reset: clears counters, window, pipeline valids and registers to 640 x 480;
//   the line memory is not cleared (stale words only meet taps outside the frame).
module gaussian_blur_3x3_rgb #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  gbr_pkg::req_payload_type           req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output gbr_pkg::rsp_payload_type           rsp_data,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [gbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [gbr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import gbr_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam logic [WW-1:0] MaxWidth = WW'(MAX_WIDTH);

   // ---------------------------------------------------------------- registers
   logic [FRAME_W_W-1:0] frame_width_ff;
   logic [FRAME_H_W-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FRAME_W_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Effective geometry: zero acts as one, width clamps to the memory depth.
   logic [WW-1:0]        width_eff;
   logic [FRAME_H_W-1:0] height_eff;
   logic [ROW_W-1:0]     height_x;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = MaxWidth;
      end else begin
         width_eff = WW'(frame_width_ff);
      end
   end

   assign height_eff = (frame_height_ff == '0) ? FRAME_H_W'(1) : frame_height_ff;
   assign height_x   = ROW_W'(height_eff);

   // ------------------------------------------------------- pipeline control
   logic              adv;
   logic              req_xfer;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_payload_type   rsp_data_ff;

   logic              s1_valid_ff;
   logic              s1_emit_ff;
   logic              s1_final_ff;
   logic              s1_fwd_ff;
   tap_mask_type      s1_mask_ff;
   pixel_type         s1_pix_ff;
   logic [CW-1:0]     s1_addr_ff;

   logic              s2_valid_ff;
   logic              s2_emit_ff;
   logic              s2_final_ff;
   tap_mask_type      s2_mask_ff;

   // Stall only when the kernel stage holds a result and the output is blocked.
   assign adv       = !(s2_valid_ff && s2_emit_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready = adv;
   assign req_xfer  = req_valid && req_ready;

   // ------------------------------------------------------- stage 0: position
   logic [WW-1:0]     col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [WW-1:0]     col_in;
   logic [ROW_W-1:0]  row_in;
   logic [WW-1:0]     cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [WW-1:0]     col_inc;
   logic              in_frame;
   logic              drop_item;
   logic              emit;
   logic              final_item;
   logic              take_item;
   tap_mask_type      mask;
   pixel_type         pix;

   always_comb begin
      // Start the next row first if the count sits at or past the width.
      if (col_ff >= width_eff) begin
         cur_col = '0;
         cur_row = row_ff + ROW_W'(1);
      end else begin
         cur_col = col_ff;
         cur_row = row_ff;
      end

      in_frame   = cur_row < height_x;
      drop_item  = in_frame && req_data.is_flush;
      emit       = (cur_row != '0 && cur_col != '0) || cur_row >= ROW_W'(2);
      final_item = cur_row > height_x;
      take_item  = req_xfer && !drop_item;

      // Outside the frame the item is padding: its channels read as zero.
      if (in_frame) begin
         pix.red   = req_data.red_in;
         pix.green = req_data.green_in;
         pix.blue  = req_data.blue_in;
      end else begin
         pix = '0;
      end

      // Column zero emits the last pixel of the row before last.
      if (cur_col == '0) begin
         mask.top_ok   = cur_row >= ROW_W'(3);
         mask.bot_ok   = cur_row <= height_x;
         mask.left_ok  = width_eff >= WW'(2);
         mask.right_ok = 1'b0;
      end else begin
         mask.top_ok   = cur_row >= ROW_W'(2);
         mask.bot_ok   = cur_row < height_x;
         mask.left_ok  = cur_col >= WW'(2);
         mask.right_ok = 1'b1;
      end

      col_inc = cur_col + WW'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (req_xfer) begin
         if (drop_item) begin
            col_in = cur_col;
            row_in = cur_row;
         end else if (final_item) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= width_eff) begin
            col_in = '0;
            row_in = cur_row + ROW_W'(1);
         end else begin
            col_in = col_inc;
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------- line memory
   line_word_type rd_word;
   line_word_type line_word;
   line_word_type wr_word;
   line_word_type wr_last_ff;
   logic          wr_en;

   assign wr_en   = adv && s1_valid_ff;
   // A word written in the cycle of its read is taken from the write register.
   assign line_word      = s1_fwd_ff ? wr_last_ff : rd_word;
   assign wr_word.upper  = line_word.middle;
   assign wr_word.middle = s1_pix_ff;

   gbr_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (take_item),
      .rd_addr (cur_col[CW-1:0]),
      .rd_data (rd_word),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wr_last_ff <= wr_word;
      end
   end

   // --------------------------------------------------- stage 1: window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= take_item;
         s1_fwd_ff   <= s1_valid_ff && (s1_addr_ff == cur_col[CW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_emit_ff  <= emit;
         s1_final_ff <= final_item;
         s1_mask_ff  <= mask;
         s1_pix_ff   <= pix;
         s1_addr_ff  <= cur_col[CW-1:0];
      end
   end

   window_type window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (wr_en) begin
         for (int i = 0; i < 3; i++) begin
            window_ff[i][0] <= window_ff[i][1];
            window_ff[i][1] <= window_ff[i][2];
         end
         window_ff[0][2] <= line_word.upper;
         window_ff[1][2] <= line_word.middle;
         window_ff[2][2] <= s1_pix_ff;
      end
   end

   // ---------------------------------------------------------- stage 2: kernel
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_emit_ff  <= s1_emit_ff;
         s2_final_ff <= s1_final_ff;
         s2_mask_ff  <= s1_mask_ff;
      end
   end

   pixel_type blurred;

   gbr_kernel u_kernel (
      .window  (window_ff),
      .mask    (s2_mask_ff),
      .blurred (blurred)
   );

   // ------------------------------------------------------- output register
   logic rsp_load;

   assign rsp_load = adv && s2_valid_ff && s2_emit_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.red_out      <= blurred.red;
         rsp_data_ff.green_out    <= blurred.green;
         rsp_data_ff.blue_out     <= blurred.blue;
         rsp_data_ff.end_of_frame <= s2_final_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------ assertions
   // Hold input while a finished result waits behind a blocked output.
   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_emit_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input transfer allowed while kernel stage is stalled");

   // Column count never runs past the memory depth.
   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      col_ff <= MaxWidth)
      else $error("column count beyond line memory depth");

   // Same-address back-to-back access only happens at column zero.
   a_fwd_col_zero : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> (s1_addr_ff == '0))
      else $error("line memory forward at a nonzero column");

   // The frame's closing item restarts the position counters.
   a_final_restart : assert property (@(posedge clock) disable iff (reset)
      (take_item && final_item) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters not cleared after end of frame");

endmodule

`default_nettype wire

/* tb/gaussian_blur_3x3_rgb_tb.sv */
// Self-checking testbench for the streaming 3x3 RGB Gaussian blur.
`timescale 1ns / 1ps

module gaussian_blur_3x3_rgb_tb;
   import gbr_pkg::*;

   localparam int MAX_WIDTH = 1024;
   // Idle time left after a drain before the next CSR write.
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS_PER_PHASE = 330;
   // Index that decodes to no register: a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] SPARE_CSR_INDEX = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_payload_type          req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data  = '0;

   // Stimulus waiting for the driver, and blurred pixels waiting for the block.
   req_payload_type pending_pixels [$];
   rsp_payload_type expected_blur [$];

   int unsigned items_queued   = 0;
   int unsigned items_accepted = 0;
   int unsigned error_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;

   // Transfer flags recorded at the rising edge, read at the next falling edge.
   bit req_taken = 1'b0;
   bit csr_taken = 1'b0;

   // Shadow copy of the block state, kept by the predictor.
   logic [FRAME_W_W-1:0] cfg_width  = FRAME_WIDTH_RESET;
   logic [FRAME_H_W-1:0] cfg_height = FRAME_HEIGHT_RESET;
   pixel_type            upper_line  [MAX_WIDTH];
   pixel_type            middle_line [MAX_WIDTH];
   pixel_type            window_px   [3][3];   // [top..bottom][left..right]
   int unsigned          col_pos = 0;
   int unsigned          row_pos = 0;

   gaussian_blur_3x3_rgb #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Blur predictor
   // ------------------------------------------------------------------

   function automatic int unsigned tap_weight(input int k);
      return (k == 1) ? 2 : 1;
   endfunction

   // Apply the 1-2-1 kernel to the window. base selects which window column acts
   // as the left tap; a tap column past the window, or a masked row/column, adds
   // nothing. The divisor stays 16 regardless of how many taps count.
   function automatic pixel_type blur_at(input int base, input bit top_ok,
                                         input bit bot_ok, input bit left_ok,
                                         input bit right_ok);
      int unsigned sum_r, sum_g, sum_b, wgt;
      int          i, j;
      bit          row_ok [3];
      bit          col_ok [3];
      pixel_type   px;
      pixel_type   res;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      row_ok[0] = top_ok;
      row_ok[1] = 1'b1;
      row_ok[2] = bot_ok;
      col_ok[0] = left_ok;
      col_ok[1] = 1'b1;
      col_ok[2] = right_ok;
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            if (row_ok[i] && col_ok[j] && base + j <= 2) begin
               px    = window_px[i][base + j];
               wgt   = tap_weight(i) * tap_weight(j);
               sum_r += px.red * wgt;
               sum_g += px.green * wgt;
               sum_b += px.blue * wgt;
            end
         end
      end
      // Round half up; the weights sum to 16 so nothing can exceed 255.
      res.red   = 8'((sum_r + 8) >> 4);
      res.green = 8'((sum_g + 8) >> 4);
      res.blue  = 8'((sum_b + 8) >> 4);
      return res;
   endfunction

   // Advance the shadow state by one accepted item and queue the blurred pixel
   // it releases, if any. Results trail the input by one row and one column.
   task automatic step_blur(input req_payload_type item);
      int unsigned     w, h, r, c, orow, ocol;
      bit              has_result, frame_done;
      pixel_type       pix, top_px, mid_px, out_px;
      rsp_payload_type res;
      w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      // A width lowered under the current column starts the next row first.
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      r = row_pos;
      c = col_pos;
      // Drop a flush that arrives while the frame is still being read in.
      if (r < h && item.is_flush)
         return;
      // While draining, every item counts as a black flush pixel.
      pix = '0;
      if (r < h) begin
         pix.red   = item.red_in;
         pix.green = item.green_in;
         pix.blue  = item.blue_in;
      end
      has_result = (r >= 1 && c >= 1) || r >= 2;
      frame_done = r >= h + 1;
      out_px     = '0;

      // At column zero the pending result is the last pixel of the row before
      // last; it still sits in the old window, so blur before shifting.
      if (has_result && c == 0) begin
         orow   = r - 2;
         ocol   = w - 1;
         out_px = blur_at(1, orow >= 1, orow + 1 < h, ocol >= 1, 1'b0);
      end

      top_px         = upper_line[c];
      mid_px         = middle_line[c];
      upper_line[c]  = mid_px;
      middle_line[c] = pix;
      for (int i = 0; i < 3; i++) begin
         window_px[i][0] = window_px[i][1];
         window_px[i][1] = window_px[i][2];
      end
      window_px[0][2] = top_px;
      window_px[1][2] = mid_px;
      window_px[2][2] = pix;

      if (has_result && c != 0) begin
         orow   = r - 1;
         ocol   = c - 1;
         out_px = blur_at(0, orow >= 1, orow + 1 < h, ocol >= 1, ocol + 1 < w);
      end

      if (frame_done) begin
         row_pos = 0;
         col_pos = 0;
      end else begin
         col_pos = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
         end
      end

      if (has_result) begin
         res.red_out      = out_px.red;
         res.green_out    = out_px.green;
         res.blue_out     = out_px.blue;
         res.end_of_frame = frame_done;
         expected_blur.push_back(res);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: present queued pixels on the request channel
   // ------------------------------------------------------------------

   // Change inputs on the falling edge only. Hold valid and the payload until
   // the transfer, then advance to the next pixel or go idle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_pixels.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result-side backpressure: drop ready at random on a fresh roll every cycle.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: track transfers at the rising edge, predict and compare
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         req_taken = 1'b0;
         csr_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         csr_taken = csr_valid && csr_ready;
         if (csr_taken) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  cfg_width  = csr_data[FRAME_W_W-1:0];
               CSR_FRAME_HEIGHT: cfg_height = csr_data[FRAME_H_W-1:0];
               default: ;
            endcase
         end
         // Predict before checking; results never share an edge with their item.
         if (req_taken) begin
            step_blur(req_data);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_blur.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected, actual r=%0d g=%0d b=%0d eof=%0d",
                        $time, rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out,
                        rsp_data.end_of_frame);
            end else begin
               want = expected_blur.pop_front();
               check_field("red_out", want.red_out, rsp_data.red_out);
               check_field("green_out", want.green_out, rsp_data.green_out);
               check_field("blue_out", want.blue_out, rsp_data.blue_out);
               check_field("end_of_frame", 8'(want.end_of_frame), 8'(rsp_data.end_of_frame));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic push_item(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic flush);
      req_payload_type item;
      item.red_in   = r;
      item.green_in = g;
      item.blue_in  = b;
      item.is_flush = flush;
      pending_pixels.push_back(item);
      items_queued++;
   endtask

   // Hold one CSR write until its transfer; the block is idle whenever this runs.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // Wait for every queued item to transfer and every blurred pixel to return,
   // then let the pipeline settle.
   task automatic wait_drained();
      while (items_accepted != items_queued || expected_blur.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Program the geometry and stream one frame with random content: pixels with
   // an occasional ignored flush ahead of them, then width + 1 drain items, some
   // of them pixels that the block must treat as flushes.
   task automatic run_frame(input logic [CSR_DATA_W-1:0] width_data,
                            input logic [CSR_DATA_W-1:0] height_data,
                            output int unsigned counted);
      int unsigned w_eff, h_eff;
      write_csr(CSR_FRAME_WIDTH, width_data);
      write_csr(CSR_FRAME_HEIGHT, height_data);
      w_eff = width_data[FRAME_W_W-1:0];
      if (w_eff == 0) w_eff = 1;
      if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
      h_eff = (height_data == 0) ? 1 : height_data;
      for (int unsigned p = 0; p < w_eff * h_eff; p++) begin
         if ($urandom_range(19) == 0)
            push_item(rand_chan(), rand_chan(), rand_chan(), 1'b1);
         push_item(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      end
      for (int unsigned d = 0; d <= w_eff; d++)
         push_item(rand_chan(), rand_chan(), rand_chan(), $urandom_range(4) != 0);
      counted = w_eff * h_eff + w_eff + 1;
      wait_drained();
   endtask

   initial begin
      int unsigned phase_items, counted, w_pick, h_pick;
      logic [7:0]  r, g, b;
      logic [4:0]  junk;

      foreach (upper_line[k]) begin
         upper_line[k]  = '0;
         middle_line[k] = '0;
      end
      foreach (window_px[i, j])
         window_px[i][j] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         if (phase == 0) begin
            // Directed 4x3 frame with saturated and black pixels, a flush ahead
            // of the frame and one in the middle (both ignored), and a pixel
            // inside the drain (taken as a flush).
            write_csr(CSR_FRAME_WIDTH, 16'd4);
            write_csr(CSR_FRAME_HEIGHT, 16'd3);
            // A write to an undecoded index must leave the geometry alone.
            write_csr(SPARE_CSR_INDEX, 16'hFFFF);
            push_item(8'd255, 8'd255, 8'd255, 1'b1);
            for (int k = 0; k < 12; k++) begin
               r = k[0] ? 8'd255 : 8'd0;
               g = (k % 3 == 0) ? 8'd255 : 8'd0;
               b = 8'(k * 23);
               if (k == 5) begin
                  r = 8'd255;
                  g = 8'd255;
                  b = 8'd255;
               end else if (k == 6) begin
                  r = 8'd0;
                  g = 8'd0;
                  b = 8'd0;
               end
               if (k == 7)
                  push_item(8'd255, 8'd255, 8'd255, 1'b1);
               push_item(r, g, b, 1'b0);
            end
            for (int d = 0; d < 5; d++) begin
               if (d == 1)
                  push_item(8'd255, 8'd255, 8'd255, 1'b0);
               else
                  push_item(8'd0, 8'd255, 8'd0, 1'b1);
            end
            wait_drained();

            // Zero width and zero height both act as one: a single-pixel frame.
            write_csr(CSR_FRAME_WIDTH, 16'd0);
            write_csr(CSR_FRAME_HEIGHT, 16'd0);
            push_item(8'd255, 8'd255, 8'd255, 1'b0);
            push_item(8'd0, 8'd0, 8'd0, 1'b1);
            push_item(8'd255, 8'd0, 8'd255, 1'b0);
            wait_drained();
         end

         // Random frames, mostly small so that many frame borders are crossed.
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS_PER_PHASE) begin
            case ($urandom_range(9))
               0:       w_pick = 0;
               1:       w_pick = 1;
               2:       w_pick = $urandom_range(13, 48);
               default: w_pick = $urandom_range(2, 12);
            endcase
            case ($urandom_range(7))
               0:       h_pick = 0;
               1:       h_pick = 1;
               default: h_pick = $urandom_range(2, 8);
            endcase
            // Bits above the width register must be dropped by the block.
            junk = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd0;
            run_frame({junk, 11'(w_pick)}, 16'(h_pick), counted);
            phase_items += counted;
         end
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
